// ===== design/rrbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin blocking scheduler package
// Shared widths, event codes and the command/status structs.
// ----------------------------------------------------------------------------
package rrbs_pkg;

    localparam int READY_DEPTH   = 16;
    localparam int BLOCKED_DEPTH = 16;
    localparam int RA_W = $clog2(READY_DEPTH);
    localparam int BA_W = $clog2(BLOCKED_DEPTH);
    localparam int RC_W = $clog2(READY_DEPTH + 1);
    localparam int BC_W = $clog2(BLOCKED_DEPTH + 1);

    localparam logic [2:0] REQ_JOIN       = 3'd0;
    localparam logic [2:0] REQ_MOVE       = 3'd1;
    localparam logic [2:0] REQ_REQUEST    = 3'd2;
    localparam logic [2:0] REQ_DELIVER    = 3'd3;
    localparam logic [2:0] REQ_DISCONNECT = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        DP_NONE    = 3'd0,
        DP_LOAD    = 3'd1,  // capture input word, run immediate event
        DP_SCAN_R  = 3'd2,  // compare one ready entry
        DP_SCAN_B  = 3'd3,  // compare one blocked entry
        DP_SHIFT_R = 3'd4,  // close gap in ready FIFO, one entry
        DP_SHIFT_B = 3'd5,  // close gap in blocked list, one entry
        DP_SELECT  = 3'd6,  // selection and result capture
        DP_POP     = 3'd7   // capture the ready head before it is shifted out
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       fin_r;   // last shift step of ready removal
        logic       fin_b;   // last shift step of blocked removal
    } t_cmd;

    typedef struct packed {
        logic       hit;        // scan entry matches
        logic       scan_end;   // scan index at the last entry
        logic       shift_end;  // shift index at the next-to-last entry, the last shift step
        logic       need_rscan; // disconnect still has to search the stores
        logic       is_deliver; // word in work is a delivery
        logic       keep;       // holder stays under its quantum
        logic       ready_nz;   // ready FIFO holds at least one client
        logic       ready_full; // ready FIFO is full
    } t_sts;

endpackage
`default_nettype wire

// ===== design/rrbs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Event, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rrbs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [5:0] client_id;
    logic [7:0] resource;
    modport source (output valid, req_type, client_id, resource, input ready);
    modport sink   (input valid, req_type, client_id, resource, output ready);
endinterface

interface rrbs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       grant_valid;
    logic [5:0] grant_id;
    logic       new_turn;
    logic       unblocked_valid;
    logic [5:0] unblocked_id;
    modport source (output valid, status, grant_valid, grant_id, new_turn,
                    unblocked_valid, unblocked_id, input ready);
    modport sink   (input valid, status, grant_valid, grant_id, new_turn,
                    unblocked_valid, unblocked_id, output ready);
endinterface

interface rrbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/rrbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready FIFO, blocked list, turn holder, scan/shift index and result word.
// ----------------------------------------------------------------------------
module rrbs_datapath
    import rrbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [2:0] i_req_type,
    input  wire logic [5:0] i_client_id,
    input  wire logic [7:0] i_resource,
    input  wire logic [7:0] i_quantum,
    output t_sts            o_sts,
    output logic [1:0]      o_status,
    output logic            o_grant_valid,
    output logic [5:0]      o_grant_id,
    output logic            o_new_turn,
    output logic            o_unblocked_valid,
    output logic [5:0]      o_unblocked_id
);

    logic [5:0] r_ready_ids   [READY_DEPTH];
    logic [5:0] r_blocked_ids [BLOCKED_DEPTH];
    logic [7:0] r_blocked_res [BLOCKED_DEPTH];
    logic [RC_W-1:0] r_rcnt;
    logic [BC_W-1:0] r_bcnt;
    logic [5:0] r_cur_id;
    logic       r_cur_v;
    logic [7:0] r_moves;
    logic [2:0] r_type;
    logic [5:0] r_id;
    logic [7:0] r_res;
    logic [7:0] r_idx;
    logic [1:0] r_status;
    logic       r_unb_v;
    logic [5:0] r_unb_id;
    logic       r_found;
    logic [5:0] r_head;
    logic       r_popped;

    logic [RA_W-1:0] ridx;
    logic [BA_W-1:0] bidx;
    logic            rfull, bfull, keep;
    logic [8:0]      idx9, idx_p1, idx_p2, rcnt9, bcnt9;

    assign ridx   = r_idx[RA_W-1:0];
    assign bidx   = r_idx[BA_W-1:0];
    assign rfull  = (r_rcnt == RC_W'(READY_DEPTH));
    assign bfull  = (r_bcnt == BC_W'(BLOCKED_DEPTH));
    assign keep   = r_cur_v && (r_moves < i_quantum);
    assign idx9   = {1'b0, r_idx};
    assign idx_p1 = idx9 + 9'd1;
    assign idx_p2 = idx9 + 9'd2;
    assign rcnt9  = {{(9-RC_W){1'b0}}, r_rcnt};
    assign bcnt9  = {{(9-BC_W){1'b0}}, r_bcnt};

    // Status back to the controller; a hit counts only on a stored entry.
    always_comb begin
        o_sts.need_rscan = (r_type == REQ_DISCONNECT) && !r_found;
        o_sts.is_deliver = (r_type == REQ_DELIVER);
        o_sts.keep       = keep;
        o_sts.ready_nz   = (r_rcnt != '0);
        o_sts.ready_full = rfull;
        if (i_cmd.op == DP_SCAN_R || i_cmd.op == DP_SHIFT_R) begin
            o_sts.hit       = (idx9 < rcnt9) && (r_ready_ids[ridx] == r_id);
            o_sts.scan_end  = (idx_p1 >= rcnt9);
            o_sts.shift_end = (idx_p2 >= rcnt9);
        end else begin
            if (r_type == REQ_DELIVER) begin
                o_sts.hit = (idx9 < bcnt9) && (r_blocked_res[bidx] == r_res);
            end else begin
                o_sts.hit = (idx9 < bcnt9) && (r_blocked_ids[bidx] == r_id);
            end
            o_sts.scan_end  = (idx_p1 >= bcnt9);
            o_sts.shift_end = (idx_p2 >= bcnt9);
        end
    end

    // Storage updates, one entry per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                if (i_req_type == REQ_JOIN && !rfull) begin
                    r_ready_ids[r_rcnt[RA_W-1:0]] <= i_client_id;
                end
                if (i_req_type == REQ_REQUEST && r_cur_v && !bfull) begin
                    r_blocked_ids[r_bcnt[BA_W-1:0]] <= r_cur_id;
                    r_blocked_res[r_bcnt[BA_W-1:0]] <= i_resource;
                end
            end
            DP_SCAN_B: begin
                if (r_type == REQ_DELIVER && o_sts.hit && !rfull) begin
                    r_ready_ids[r_rcnt[RA_W-1:0]] <= r_blocked_ids[bidx];
                end
            end
            DP_SHIFT_R: begin
                // Copy while a later entry exists.
                if (!o_sts.scan_end) begin
                    r_ready_ids[ridx] <= r_ready_ids[RA_W'(r_idx + 8'd1)];
                end
            end
            DP_SHIFT_B: begin
                if (!o_sts.scan_end) begin
                    r_blocked_ids[bidx] <= r_blocked_ids[BA_W'(r_idx + 8'd1)];
                    r_blocked_res[bidx] <= r_blocked_res[BA_W'(r_idx + 8'd1)];
                end
            end
            DP_SELECT: begin
                // Rotation: the head is already popped, append the old holder.
                if (!keep && r_popped && r_cur_v) begin
                    r_ready_ids[r_rcnt[RA_W-1:0]] <= r_cur_id;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt   <= '0;
            r_bcnt   <= '0;
            r_cur_id <= '0;
            r_cur_v  <= 1'b0;
            r_moves  <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_type   <= '0;
            r_id     <= '0;
            r_res    <= '0;
            r_status <= ST_OK;
            r_unb_v  <= 1'b0;
            r_unb_id <= '0;
            r_head   <= '0;
            r_popped <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LOAD: begin
                    r_type   <= i_req_type;
                    r_id     <= i_client_id;
                    r_res    <= i_resource;
                    r_idx    <= '0;
                    r_unb_v  <= 1'b0;
                    r_unb_id <= '0;
                    r_popped <= 1'b0;
                    r_found  <= (i_req_type == REQ_DISCONNECT) && r_cur_v &&
                                (r_cur_id == i_client_id);
                    case (i_req_type)
                        REQ_JOIN: begin
                            r_status <= rfull ? ST_FULL : ST_OK;
                            if (!rfull) begin
                                r_rcnt <= r_rcnt + RC_W'(1);
                            end
                        end
                        REQ_MOVE: begin
                            r_status <= ST_OK;
                            if (r_cur_v && r_moves != 8'hFF) begin
                                r_moves <= r_moves + 8'd1;
                            end
                        end
                        REQ_REQUEST: begin
                            r_status <= (r_cur_v && bfull) ? ST_FULL : ST_OK;
                            if (r_cur_v && !bfull) begin
                                r_bcnt   <= r_bcnt + BC_W'(1);
                                r_cur_v  <= 1'b0;
                                r_cur_id <= '0;
                                r_moves  <= '0;
                            end
                        end
                        REQ_DISCONNECT: begin
                            r_status <= ST_OK;
                            if (r_cur_v && r_cur_id == i_client_id) begin
                                r_cur_v  <= 1'b0;
                                r_cur_id <= '0;
                                r_moves  <= '0;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                        end
                    endcase
                end
                DP_SCAN_R: begin
                    if (o_sts.hit) begin
                        r_found <= 1'b1;
                    end else if (o_sts.scan_end) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                DP_SCAN_B: begin
                    if (o_sts.hit) begin
                        r_found <= 1'b1;
                        if (r_type == REQ_DELIVER) begin
                            if (rfull) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_unb_v  <= 1'b1;
                                r_unb_id <= r_blocked_ids[bidx];
                                r_rcnt   <= r_rcnt + RC_W'(1);
                            end
                        end
                    end else if (!o_sts.scan_end) begin
                        r_idx <= r_idx + 8'd1;
                    end else if (r_type == REQ_DISCONNECT) begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                DP_SHIFT_R: begin
                    if (i_cmd.fin_r) begin
                        r_rcnt <= r_rcnt - RC_W'(1);
                        r_idx  <= '0;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                DP_SHIFT_B: begin
                    if (i_cmd.fin_b) begin
                        r_bcnt <= r_bcnt - BC_W'(1);
                        r_idx  <= '0;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                DP_POP: begin
                    r_head   <= r_ready_ids[0];
                    r_popped <= 1'b1;
                    r_idx    <= '0;
                end
                DP_SELECT: begin
                    // The popped head takes the turn; the old holder rejoins the tail.
                    if (!keep) begin
                        r_moves <= '0;
                        if (r_popped) begin
                            r_cur_id <= r_head;
                            r_cur_v  <= 1'b1;
                            if (r_cur_v) begin
                                r_rcnt <= r_rcnt + RC_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_new_turn <= 1'b0;
        end else if (i_cmd.op == DP_SELECT) begin
            o_status          <= r_status;
            o_unblocked_valid <= r_unb_v;
            o_unblocked_id    <= r_unb_id;
            if (keep) begin
                o_grant_valid <= 1'b1;
                o_grant_id    <= r_cur_id;
                o_new_turn    <= 1'b0;
            end else if (r_popped) begin
                o_grant_valid <= 1'b1;
                o_grant_id    <= r_head;
                o_new_turn    <= 1'b1;
            end else begin
                o_grant_valid <= r_cur_v;
                o_grant_id    <= r_cur_v ? r_cur_id : 6'd0;
                o_new_turn    <= r_cur_v;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/rrbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences load, scan, shift, head pop and selection for one event word.
// ----------------------------------------------------------------------------
module rrbs_ctrl
    import rrbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DISP   = 8'b0000_0010,
        S_SCAN_R = 8'b0000_0100,
        S_SCAN_B = 8'b0000_1000,
        S_SHF_R  = 8'b0001_0000,
        S_SHF_B  = 8'b0010_0000,
        S_POP    = 8'b0100_0000,
        S_SEL    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   r_popping, n_popping;
    logic   sel_fire;

    // Selection waits until the previous result word has left.
    assign sel_fire    = (r_state == S_SEL) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_popping   = r_popping;
        o_cmd.op    = DP_NONE;
        o_cmd.fin_r = 1'b0;
        o_cmd.fin_b = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op  = DP_LOAD;
                    n_popping = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.need_rscan) begin
                    n_state = i_sts.ready_nz ? S_SCAN_R : S_SCAN_B;
                end else if (i_sts.is_deliver) begin
                    n_state = S_SCAN_B;
                end else begin
                    n_state = S_POP;
                end
            end
            S_SCAN_R: begin
                o_cmd.op = DP_SCAN_R;
                if (i_sts.hit) begin
                    n_state = S_SHF_R;
                end else if (i_sts.scan_end) begin
                    n_state = S_SCAN_B;
                end
            end
            S_SCAN_B: begin
                o_cmd.op = DP_SCAN_B;
                if (i_sts.hit && !(i_sts.is_deliver && i_sts.ready_full)) begin
                    n_state = S_SHF_B;
                end else if (i_sts.hit || i_sts.scan_end) begin
                    n_state = S_POP;
                end
            end
            S_SHF_R: begin
                o_cmd.op    = DP_SHIFT_R;
                o_cmd.fin_r = i_sts.shift_end;
                if (i_sts.shift_end) begin
                    n_state = r_popping ? S_SEL : S_POP;
                end
            end
            S_SHF_B: begin
                o_cmd.op    = DP_SHIFT_B;
                o_cmd.fin_b = i_sts.shift_end;
                if (i_sts.shift_end) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                // Pop the ready head when the holder loses the turn.
                if (!i_sts.keep && i_sts.ready_nz) begin
                    o_cmd.op  = DP_POP;
                    n_popping = 1'b1;
                    n_state   = S_SHF_R;
                end else begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (sel_fire) begin
                    o_cmd.op = DP_SELECT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_popping   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_popping <= n_popping;
            if (sel_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/round_robin_blocking_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin blocking scheduler
// Quantum-based turn scheduler with a ready FIFO and a blocked list.
// ----------------------------------------------------------------------------
//  Channel | Dir | Carries
//  ev      | in  | req_type, client_id, resource
//  res     | out | status, grant, new_turn, unblocked
//  cfg     | in  | quantum
//
// With no store walked, a word runs through load, dispatch, pop check and
// selection between one accept and the next. Searches and shifts step through
// the stores one entry at a time, and a rotation shifts the ready FIFO after its
// pop; worst case is a disconnect walking both full stores before a full pop.
// Reset is synchronous, active low; quantum resets to 3.
// A finished result waits in the output register while the next word is
// accepted and worked on; only selection stalls until that result leaves.
// ----------------------------------------------------------------------------
module round_robin_blocking_scheduler
    import rrbs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrbs_in_if.sink    ev,
    rrbs_out_if.source res,
    rrbs_cfg_if.sink   cfg
);

    logic [7:0] r_quantum;
    t_cmd       cmd;
    t_sts       sts;

    assign cfg.ready = 1'b1;

    // Quantum register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= 8'd3;
        end else if (cfg.valid && cfg.ready) begin
            r_quantum <= cfg.data;
        end
    end

    rrbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (ev.valid),
        .o_in_ready  (ev.ready),
        .o_out_valid (res.valid),
        .i_out_ready (res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rrbs_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_req_type        (ev.req_type),
        .i_client_id       (ev.client_id),
        .i_resource        (ev.resource),
        .i_quantum         (r_quantum),
        .o_sts             (sts),
        .o_status          (res.status),
        .o_grant_valid     (res.grant_valid),
        .o_grant_id        (res.grant_id),
        .o_new_turn        (res.new_turn),
        .o_unblocked_valid (res.unblocked_valid),
        .o_unblocked_id    (res.unblocked_id)
    );

endmodule
`default_nettype wire

// ===== verif/rrbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the event, result and quantum channels, keeps its own copy of the
// scheduler state, predicts one result word per accepted event word and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module rrbs_checker
    import rrbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrbs_in_if        ev,
    rrbs_out_if       res,
    rrbs_cfg_if       cfg,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [1:0] status;
        logic       grant_valid;
        logic [5:0] grant_id;
        logic       new_turn;
        logic       unblocked_valid;
        logic [5:0] unblocked_id;
    } t_sched_result;

    // Mirror of the scheduler state.
    logic [7:0] quantum_q;
    logic [5:0] ready_q[$];
    logic [5:0] blocked_id_q[$];
    logic [7:0] blocked_res_q[$];
    logic [5:0] holder_id;
    logic       holder_valid;
    logic [7:0] moves_used;
    t_sched_result pending_results[$];

    // Apply one event word to the mirror and return the expected result.
    function automatic t_sched_result schedule_event(logic [2:0] kind, logic [5:0] id,
                                                     logic [7:0] rsrc);
        t_sched_result r;
        logic [5:0] nxt;
        bit found;
        int pos;
        r = '0;
        pos = -1;
        found = 0;
        case (kind)
            REQ_JOIN: begin
                if (ready_q.size() >= READY_DEPTH) r.status = ST_FULL;
                else ready_q.push_back(id);
            end
            REQ_MOVE: begin
                if (holder_valid && moves_used < 8'd255) moves_used++;
            end
            REQ_REQUEST: begin
                if (holder_valid) begin
                    if (blocked_id_q.size() >= BLOCKED_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        blocked_id_q.push_back(holder_id);
                        blocked_res_q.push_back(rsrc);
                        holder_valid = 0;
                        holder_id = '0;
                        moves_used = '0;
                    end
                end
            end
            REQ_DELIVER: begin
                for (int i = 0; i < blocked_res_q.size(); i++)
                    if (pos < 0 && blocked_res_q[i] == rsrc) pos = i;
                if (pos >= 0) begin
                    if (ready_q.size() >= READY_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        r.unblocked_valid = 1;
                        r.unblocked_id = blocked_id_q[pos];
                        ready_q.push_back(blocked_id_q[pos]);
                        blocked_id_q.delete(pos);
                        blocked_res_q.delete(pos);
                    end
                end
            end
            REQ_DISCONNECT: begin
                if (holder_valid && holder_id == id) begin
                    holder_valid = 0;
                    holder_id = '0;
                    moves_used = '0;
                    found = 1;
                end
                for (int i = 0; !found && i < ready_q.size(); i++)
                    if (ready_q[i] == id) begin
                        ready_q.delete(i);
                        found = 1;
                    end
                for (int i = 0; !found && i < blocked_id_q.size(); i++)
                    if (blocked_id_q[i] == id) begin
                        blocked_id_q.delete(i);
                        blocked_res_q.delete(i);
                        found = 1;
                    end
                if (!found) r.status = ST_NOT_FOUND;
            end
            default: ;
        endcase

        // Selection: keep the turn under quantum, else rotate.
        if (!(holder_valid && moves_used < quantum_q)) begin
            if (ready_q.size() > 0) begin
                nxt = ready_q.pop_front();
                if (holder_valid) ready_q.push_back(holder_id);
                holder_id = nxt;
                holder_valid = 1;
                moves_used = '0;
                r.new_turn = 1;
            end else if (holder_valid) begin
                moves_used = '0;
                r.new_turn = 1;
            end
        end
        r.grant_valid = holder_valid;
        r.grant_id = holder_valid ? holder_id : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (!i_rst_n) begin
            quantum_q <= 8'd3;
            ready_q.delete();
            blocked_id_q.delete();
            blocked_res_q.delete();
            holder_id = '0;
            holder_valid = 0;
            moves_used = '0;
            pending_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (cfg.valid && cfg.ready) quantum_q <= cfg.data;
            if (ev.valid && ev.ready)
                pending_results.push_back(schedule_event(ev.req_type, ev.client_id,
                                                         ev.resource));
            if (res.valid && res.ready) begin
                got = '{res.status, res.grant_valid, res.grant_id, res.new_turn,
                        res.unblocked_valid, res.unblocked_id};
                if (pending_results.size() == 0) begin
                    $error("result word with no event outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) o_fail_count <= o_fail_count + 1;
                    if (got.status != want.status)
                        $error("status exp %0d got %0d", want.status, got.status);
                    if (got.grant_valid != want.grant_valid)
                        $error("grant_valid exp %0d got %0d", want.grant_valid,
                               got.grant_valid);
                    if (got.grant_id != want.grant_id)
                        $error("grant_id exp %0d got %0d", want.grant_id, got.grant_id);
                    if (got.new_turn != want.new_turn)
                        $error("new_turn exp %0d got %0d", want.new_turn, got.new_turn);
                    if (got.unblocked_valid != want.unblocked_valid)
                        $error("unblocked_valid exp %0d got %0d", want.unblocked_valid,
                               got.unblocked_valid);
                    if (got.unblocked_id != want.unblocked_id)
                        $error("unblocked_id exp %0d got %0d", want.unblocked_id,
                               got.unblocked_id);
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== verif/tb_round_robin_blocking_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives directed and random event words and quantum writes into the
// scheduler with random idling on both sides; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_round_robin_blocking_scheduler;
    import rrbs_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count;
    int   pending;
    bit   calm = 0;   // no idling near the end of the run
    bit   drain_done = 0;

    rrbs_in_if  ev();
    rrbs_out_if res();
    rrbs_cfg_if cfg();

    round_robin_blocking_scheduler dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .ev     (ev),
        .res    (res),
        .cfg    (cfg)
    );

    rrbs_checker checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .ev          (ev),
        .res         (res),
        .cfg         (cfg),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        ev.valid = 0;
        ev.req_type = '0;
        ev.client_id = '0;
        ev.resource = '0;
        cfg.valid = 0;
        cfg.data = '0;
        res.ready = 0;
    end

    // Result side: ready drops in random bursts.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            res.ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 16);
                res.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Send one event word, with an optional idle burst first. Valid stays
    // high after the accept so that back-to-back words need no second drive.
    task automatic send_event(logic [2:0] kind, logic [5:0] id, logic [7:0] rsrc);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            ev.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        ev.valid <= 1;
        ev.req_type <= kind;
        ev.client_id <= id;
        ev.resource <= rsrc;
        @(posedge i_clk);
        while (!ev.ready) @(posedge i_clk);
    endtask

    // Stop sending, wait until every result is back, then let the block settle.
    task automatic wait_idle();
        ev.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [7:0] q);
        wait_idle();
        cfg.valid <= 1;
        cfg.data <= q;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    // Random word: mostly scheduler traffic on a small id and resource pool.
    task automatic random_event();
        int pick;
        logic [2:0] kind;
        logic [5:0] id;
        logic [7:0] rsrc;
        pick = $urandom_range(0, 99);
        if (pick < 25) kind = REQ_JOIN;
        else if (pick < 55) kind = REQ_MOVE;
        else if (pick < 70) kind = REQ_REQUEST;
        else if (pick < 83) kind = REQ_DELIVER;
        else if (pick < 97) kind = REQ_DISCONNECT;
        else kind = 3'($urandom_range(5, 7));
        id = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
        rsrc = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        send_event(kind, id, rsrc);
    endtask

    initial begin
        logic [7:0] qset[5];
        qset = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd5};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-scheduler cases, extremes and a full ready FIFO.
        send_event(REQ_MOVE, 6'd0, 8'd0);
        send_event(REQ_REQUEST, 6'd0, 8'd0);
        send_event(REQ_DISCONNECT, 6'd63, 8'd0);
        send_event(REQ_DELIVER, 6'd0, 8'd255);
        send_event(3'd7, 6'd0, 8'd0);
        send_event(REQ_JOIN, 6'd63, 8'd0);
        send_event(REQ_MOVE, 6'd0, 8'd0);
        send_event(REQ_REQUEST, 6'd0, 8'd255);
        send_event(REQ_DELIVER, 6'd0, 8'd255);
        for (int i = 0; i < 18; i++) send_event(REQ_JOIN, 6'(i), 8'd0);
        send_event(REQ_DELIVER, 6'd0, 8'd255);
        send_event(REQ_DISCONNECT, 6'd7, 8'd0);

        // Random phases across several quantum settings.
        for (int p = 0; p < 5; p++) begin
            write_quantum(qset[p]);
            // Fill the blocked list in the second phase to reach its full case.
            if (p == 1) begin
                for (int i = 0; i < 20; i++) begin
                    send_event(REQ_JOIN, 6'(i + 20), 8'd0);
                    send_event(REQ_REQUEST, 6'd0, 8'(i));
                end
            end
            for (int n = 0; n < 300; n++) begin
                if (p == 4 && n == 200) calm = 1;
                if (n == 150 && p == 2) wait_idle();
                random_event();
            end
        end

        wait_idle();
        drain_done = 1;
    end

    initial begin
        wait (drain_done);
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
